FILE: rtl/two_wire_sensor_bus_master_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-wire sensor bus master
// Small wrappers so that checks in the RTL read as one line each
// ----------------------------------------------------------------------------
`ifndef TWO_WIRE_SENSOR_BUS_MASTER_ASSERT_SVH
`define TWO_WIRE_SENSOR_BUS_MASTER_ASSERT_SVH

// same-cycle implication, checked only while out of reset
`define TWSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("twsb check failed");

// next-cycle implication, checked only while out of reset
`define TWSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("twsb check failed");

`endif

FILE: rtl/twsb_pkg.sv
// ----------------------------------------------------------------------------
// twsb_pkg
// Phase codes, command codes and bit tables of the two-wire sensor bus master
// ----------------------------------------------------------------------------
package twsb_pkg;

	// command codes carried in the kind field
	localparam logic [2:0] KIND_TICK         = 3'd0;
	localparam logic [2:0] KIND_SOFT_RESET   = 3'd1;
	localparam logic [2:0] KIND_MEAS_TEMP    = 3'd2;
	localparam logic [2:0] KIND_MEAS_HUM     = 3'd3;
	localparam logic [2:0] KIND_READ_STATUS  = 3'd4;
	localparam logic [2:0] KIND_WRITE_STATUS = 3'd5;

	// command bytes placed on the bus
	localparam logic [7:0] CMD_SOFT_RESET   = 8'h1e;
	localparam logic [7:0] CMD_MEAS_TEMP    = 8'h03;
	localparam logic [7:0] CMD_MEAS_HUM     = 8'h05;
	localparam logic [7:0] CMD_READ_STATUS  = 8'h07;
	localparam logic [7:0] CMD_WRITE_STATUS = 8'h06;
	localparam logic [7:0] CMD_NONE         = 8'h00;

	localparam logic [17:0] TIMEOUT_RESET = 18'd131070;

	// transmission start pattern, bit k is step k
	localparam logic [6:0] START_DATA = 7'b1100011;
	localparam logic [6:0] START_SCK  = 7'b0110110;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_CR_INIT  = 5'd1,
		PH_CR_HIGH  = 5'd2,
		PH_CR_LOW   = 5'd3,
		PH_TS_FIRST = 5'd4,
		PH_TS_1     = 5'd5,
		PH_TS_2     = 5'd6,
		PH_TS_3     = 5'd7,
		PH_TS_4     = 5'd8,
		PH_TS_5     = 5'd9,
		PH_TS_LAST  = 5'd10,
		PH_WB_SET   = 5'd11,
		PH_WB_HIGH  = 5'd12,
		PH_WB_LOW   = 5'd13,
		PH_WB_REL   = 5'd14,
		PH_WB_AHIGH = 5'd15,
		PH_WB_ALOW  = 5'd16,
		PH_WAIT     = 5'd17,
		PH_RB_HIGH  = 5'd18,
		PH_RB_LOW   = 5'd19,
		PH_RB_ASET  = 5'd20,
		PH_RB_AHIGH = 5'd21,
		PH_RB_ALOW  = 5'd22,
		PH_RB_REL   = 5'd23
	} phase_t;

	// command byte sent on the bus for each kind
	function automatic logic [7:0] cmd_byte(input logic [2:0] kind);
		logic [7:0] b;
		unique case (kind)
			KIND_SOFT_RESET:   b = CMD_SOFT_RESET;
			KIND_MEAS_TEMP:    b = CMD_MEAS_TEMP;
			KIND_MEAS_HUM:     b = CMD_MEAS_HUM;
			KIND_READ_STATUS:  b = CMD_READ_STATUS;
			KIND_WRITE_STATUS: b = CMD_WRITE_STATUS;
			default:           b = CMD_NONE;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/two_wire_sensor_bus_master.sv
// ----------------------------------------------------------------------------
// two_wire_sensor_bus_master
// Tick-level master for a two-wire humidity/temperature sensor bus
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | kind, write_value, data_in (one bus tick)
//  output   | out_valid / out_stall| pin levels, busy/done, read data, errors
//  config   | cfg_valid / cfg_ready| timeout_ticks
//
//  one input word per clock while neither side stalls, each gives exactly one output word
//  the path runs input register, phase step logic, result register
//  the phase registers advance only when the input word moves into the
//  result register, so stalls on either side never skip or repeat a tick
//  arst_n clears all control and sequencer state, timeout_ticks to 131070
//  cfg_ready is always high, the timeout may be rewritten between words
//
`include "two_wire_sensor_bus_master_assert.svh"

module two_wire_sensor_bus_master (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [17:0] timeout_ticks,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  write_value,
	input  logic        data_in,
	// output words
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sck_level,
	output logic        data_drive_enable,
	output logic        data_drive_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [15:0] read_value,
	output logic [7:0]  checksum,
	output logic [1:0]  error_count
);

	// input register
	logic        v_s1;
	logic [2:0]  kind_s1;
	logic [7:0]  wval_s1;
	logic        din_s1;

	// result register
	logic        v_s2;
	logic        sck_s2, en_s2, lvl_s2, busy_s2, done_s2;
	logic [15:0] rval_s2;
	logic [7:0]  csum_s2;
	logic [1:0]  err_s2;

	// sequencer state
	logic [17:0]        timeout_q;
	twsb_pkg::phase_t   phase_q;
	logic [2:0]         cmd_q;
	logic [3:0]         bit_q;
	logic [1:0]         byte_q;
	logic [7:0]         shift_q;
	logic [7:0]         pend_q;
	logic [15:0]        res_q;
	logic [7:0]         csum_q;
	logic [17:0]        wait_q;
	logic [1:0]         err_q;

	// state as seen by this tick, after a possible command launch
	logic               start;
	twsb_pkg::phase_t   ph_e;
	logic [2:0]         cmd_e;
	logic [3:0]         bit_e;
	logic [1:0]         byte_e;
	logic [7:0]         shift_e;
	logic [7:0]         pend_e;
	logic [15:0]        res_e;
	logic [7:0]         csum_e;
	logic [17:0]        wait_e;
	logic [1:0]         err_e;

	// next state
	twsb_pkg::phase_t   ph_n;
	logic [3:0]         bit_n;
	logic [1:0]         byte_n;
	logic [7:0]         shift_n;
	logic [15:0]        res_n;
	logic [7:0]         csum_n;
	logic [17:0]        wait_n;
	logic [1:0]         err_n;

	// pin and status outputs of this tick
	logic        sck_c, en_c, lvl_c, busy_c, done_c;

	logic        adv;
	logic        rb_last;
	logic [4:0]  ts_off;
	logic [2:0]  ts_k;
	logic [1:0]  err_inc;
	logic [3:0]  bit_inc;
	logic [17:0] wait_inc;
	logic [7:0]  shift_in;

	// word moves from input register to result register
	assign adv      = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= twsb_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= timeout_ticks;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			wval_s1 <= write_value;
			din_s1  <= data_in;
		end
	end

	// command launch from idle happens on the same tick as its first step
	always_comb begin
		start   = (phase_q == twsb_pkg::PH_IDLE) &&
			(kind_s1 >= twsb_pkg::KIND_SOFT_RESET) &&
			(kind_s1 <= twsb_pkg::KIND_WRITE_STATUS);
		ph_e    = phase_q;
		cmd_e   = cmd_q;
		bit_e   = bit_q;
		byte_e  = byte_q;
		shift_e = shift_q;
		pend_e  = pend_q;
		res_e   = res_q;
		csum_e  = csum_q;
		wait_e  = wait_q;
		err_e   = err_q;
		if (start) begin
			cmd_e   = kind_s1;
			err_e   = 2'd0;
			res_e   = 16'd0;
			csum_e  = 8'd0;
			wait_e  = 18'd0;
			bit_e   = 4'd0;
			byte_e  = 2'd0;
			shift_e = 8'd0;
			if (kind_s1 == twsb_pkg::KIND_WRITE_STATUS) begin
				pend_e = wval_s1;
			end
			ph_e = (kind_s1 == twsb_pkg::KIND_SOFT_RESET) ?
				twsb_pkg::PH_CR_INIT : twsb_pkg::PH_TS_FIRST;
		end
	end

	// shared helpers of the step logic
	assign rb_last  = (cmd_e == twsb_pkg::KIND_READ_STATUS) ? (byte_e >= 2'd1)
		: (byte_e >= 2'd2);
	assign ts_off   = ph_e - twsb_pkg::PH_TS_FIRST;
	assign ts_k     = ts_off[2:0];
	assign err_inc  = (err_e == 2'd3) ? err_e : err_e + 2'd1;
	assign bit_inc  = bit_e + 4'd1;
	assign wait_inc = wait_e + 18'd1;
	assign shift_in = {shift_e[6:0], din_s1};

	// next state
	always_comb begin
		ph_n    = ph_e;
		bit_n   = bit_e;
		byte_n  = byte_e;
		shift_n = shift_e;
		res_n   = res_e;
		csum_n  = csum_e;
		wait_n  = wait_e;
		err_n   = err_e;
		unique case (ph_e) inside
			twsb_pkg::PH_IDLE: begin
			end
			twsb_pkg::PH_TS_FIRST, twsb_pkg::PH_TS_1, twsb_pkg::PH_TS_2,
			twsb_pkg::PH_TS_3, twsb_pkg::PH_TS_4, twsb_pkg::PH_TS_5: begin
				ph_n = twsb_pkg::phase_t'(ph_e + 5'd1);
			end
			twsb_pkg::PH_TS_LAST: begin
				shift_n = twsb_pkg::cmd_byte(cmd_e);
				bit_n   = 4'd0;
				byte_n  = 2'd0;
				ph_n    = twsb_pkg::PH_WB_SET;
			end
			twsb_pkg::PH_CR_INIT: begin
				bit_n = 4'd0;
				ph_n  = twsb_pkg::PH_CR_HIGH;
			end
			twsb_pkg::PH_CR_HIGH: begin
				ph_n = twsb_pkg::PH_CR_LOW;
			end
			twsb_pkg::PH_CR_LOW: begin
				if (bit_inc >= 4'd9) begin
					bit_n = 4'd0;
					ph_n  = twsb_pkg::PH_TS_FIRST;
				end else begin
					bit_n = bit_inc;
					ph_n  = twsb_pkg::PH_CR_HIGH;
				end
			end
			twsb_pkg::PH_WB_SET: begin
				ph_n = twsb_pkg::PH_WB_HIGH;
			end
			twsb_pkg::PH_WB_HIGH: begin
				ph_n = twsb_pkg::PH_WB_LOW;
			end
			twsb_pkg::PH_WB_LOW: begin
				shift_n = {shift_e[6:0], 1'b0};
				bit_n   = bit_inc;
				ph_n    = (bit_inc >= 4'd8) ? twsb_pkg::PH_WB_REL : twsb_pkg::PH_WB_SET;
			end
			twsb_pkg::PH_WB_REL: begin
				ph_n = twsb_pkg::PH_WB_AHIGH;
			end
			twsb_pkg::PH_WB_AHIGH: begin
				ph_n = twsb_pkg::PH_WB_ALOW;
			end
			twsb_pkg::PH_WB_ALOW: begin
				if (din_s1) begin
					err_n = err_inc;
				end
				bit_n = 4'd0;
				if (cmd_e == twsb_pkg::KIND_WRITE_STATUS && byte_e == 2'd0) begin
					byte_n  = 2'd1;
					shift_n = pend_e;
					ph_n    = twsb_pkg::PH_WB_SET;
				end else if (cmd_e == twsb_pkg::KIND_MEAS_TEMP ||
					cmd_e == twsb_pkg::KIND_MEAS_HUM) begin
					wait_n = 18'd0;
					ph_n   = twsb_pkg::PH_WAIT;
				end else if (cmd_e == twsb_pkg::KIND_READ_STATUS) begin
					byte_n  = 2'd0;
					shift_n = 8'd0;
					ph_n    = twsb_pkg::PH_RB_HIGH;
				end else begin
					ph_n = twsb_pkg::PH_IDLE;
				end
			end
			twsb_pkg::PH_WAIT: begin
				// sensor pulls data low when the measurement is ready
				if (din_s1) begin
					wait_n = wait_inc;
					if (wait_inc >= timeout_q) begin
						err_n   = err_inc;
						ph_n    = twsb_pkg::PH_RB_HIGH;
						byte_n  = 2'd0;
						bit_n   = 4'd0;
						shift_n = 8'd0;
					end
				end else begin
					ph_n    = twsb_pkg::PH_RB_HIGH;
					byte_n  = 2'd0;
					bit_n   = 4'd0;
					shift_n = 8'd0;
				end
			end
			twsb_pkg::PH_RB_HIGH: begin
				ph_n = twsb_pkg::PH_RB_LOW;
			end
			twsb_pkg::PH_RB_LOW: begin
				shift_n = shift_in;
				bit_n   = bit_inc;
				if (bit_inc >= 4'd8) begin
					if (rb_last) begin
						csum_n = shift_in;
					end else if (cmd_e == twsb_pkg::KIND_READ_STATUS) begin
						res_n = {8'd0, shift_in};
					end else if (byte_e == 2'd0) begin
						res_n = {shift_in, 8'd0};
					end else begin
						res_n = {res_e[15:8], shift_in};
					end
					ph_n = twsb_pkg::PH_RB_ASET;
				end else begin
					ph_n = twsb_pkg::PH_RB_HIGH;
				end
			end
			twsb_pkg::PH_RB_ASET: begin
				ph_n = twsb_pkg::PH_RB_AHIGH;
			end
			twsb_pkg::PH_RB_AHIGH: begin
				ph_n = twsb_pkg::PH_RB_ALOW;
			end
			twsb_pkg::PH_RB_ALOW: begin
				ph_n = twsb_pkg::PH_RB_REL;
			end
			twsb_pkg::PH_RB_REL: begin
				if (rb_last) begin
					ph_n = twsb_pkg::PH_IDLE;
				end else begin
					byte_n  = byte_e + 2'd1;
					bit_n   = 4'd0;
					shift_n = 8'd0;
					ph_n    = twsb_pkg::PH_RB_HIGH;
				end
			end
			default: begin
				ph_n = twsb_pkg::PH_IDLE;
			end
		endcase
	end

	// pin levels and status of this tick
	always_comb begin
		sck_c  = 1'b0;
		en_c   = 1'b0;
		lvl_c  = 1'b0;
		busy_c = (ph_e != twsb_pkg::PH_IDLE);
		done_c = 1'b0;
		unique case (ph_e) inside
			twsb_pkg::PH_IDLE, twsb_pkg::PH_WB_REL, twsb_pkg::PH_WAIT,
			twsb_pkg::PH_RB_LOW: begin
			end
			twsb_pkg::PH_TS_FIRST, twsb_pkg::PH_TS_1, twsb_pkg::PH_TS_2,
			twsb_pkg::PH_TS_3, twsb_pkg::PH_TS_4, twsb_pkg::PH_TS_5,
			twsb_pkg::PH_TS_LAST: begin
				en_c  = 1'b1;
				lvl_c = twsb_pkg::START_DATA[ts_k];
				sck_c = twsb_pkg::START_SCK[ts_k];
			end
			twsb_pkg::PH_CR_INIT, twsb_pkg::PH_CR_LOW: begin
				en_c  = 1'b1;
				lvl_c = 1'b1;
			end
			twsb_pkg::PH_CR_HIGH: begin
				en_c  = 1'b1;
				lvl_c = 1'b1;
				sck_c = 1'b1;
			end
			twsb_pkg::PH_WB_SET, twsb_pkg::PH_WB_LOW: begin
				en_c  = 1'b1;
				lvl_c = shift_e[7];
			end
			twsb_pkg::PH_WB_HIGH: begin
				en_c  = 1'b1;
				lvl_c = shift_e[7];
				sck_c = 1'b1;
			end
			twsb_pkg::PH_WB_AHIGH, twsb_pkg::PH_RB_HIGH: begin
				sck_c = 1'b1;
			end
			twsb_pkg::PH_WB_ALOW: begin
				done_c = !(cmd_e == twsb_pkg::KIND_WRITE_STATUS && byte_e == 2'd0) &&
					(cmd_e != twsb_pkg::KIND_MEAS_TEMP) &&
					(cmd_e != twsb_pkg::KIND_MEAS_HUM) &&
					(cmd_e != twsb_pkg::KIND_READ_STATUS);
			end
			twsb_pkg::PH_RB_ASET, twsb_pkg::PH_RB_ALOW: begin
				// master ack, withheld after the checksum
				en_c  = 1'b1;
				lvl_c = rb_last;
			end
			twsb_pkg::PH_RB_AHIGH: begin
				en_c  = 1'b1;
				lvl_c = rb_last;
				sck_c = 1'b1;
			end
			twsb_pkg::PH_RB_REL: begin
				done_c = rb_last;
			end
			default: begin
				busy_c = 1'b0;
			end
		endcase
	end

	// sequencer registers step once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= twsb_pkg::PH_IDLE;
			cmd_q   <= 3'd0;
			bit_q   <= 4'd0;
			byte_q  <= 2'd0;
			shift_q <= 8'd0;
			pend_q  <= 8'd0;
			res_q   <= 16'd0;
			csum_q  <= 8'd0;
			wait_q  <= 18'd0;
			err_q   <= 2'd0;
		end else if (adv) begin
			phase_q <= ph_n;
			cmd_q   <= cmd_e;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			pend_q  <= pend_e;
			res_q   <= res_n;
			csum_q  <= csum_n;
			wait_q  <= wait_n;
			err_q   <= err_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || !out_stall) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sck_s2  <= sck_c;
			en_s2   <= en_c;
			lvl_s2  <= lvl_c;
			busy_s2 <= busy_c;
			done_s2 <= done_c;
			// result fields only carry data on the finishing tick
			rval_s2 <= done_c ? res_n : 16'd0;
			csum_s2 <= done_c ? csum_n : 8'd0;
			err_s2  <= done_c ? err_n : 2'd0;
		end
	end

	assign out_valid         = v_s2;
	assign sck_level         = sck_s2;
	assign data_drive_enable = en_s2;
	assign data_drive_level  = lvl_s2;
	assign busy_res          = busy_s2;
	assign done_res          = done_s2;
	assign read_value        = rval_s2;
	assign checksum          = csum_s2;
	assign error_count       = err_s2;

	`TWSB_ASSERT_NOW(a_done_busy, clk, arst_n, v_s2 && done_s2, busy_s2)
	`TWSB_ASSERT_NOW(a_res_on_done, clk, arst_n, v_s2 && !done_s2,
		rval_s2 == 16'd0 && csum_s2 == 8'd0 && err_s2 == 2'd0)
	`TWSB_ASSERT_NOW(a_lvl_needs_en, clk, arst_n, v_s2 && !en_s2, !lvl_s2)
	`TWSB_ASSERT_NEXT(a_idle_holds, clk, arst_n,
		adv && phase_q == twsb_pkg::PH_IDLE && !start, phase_q == twsb_pkg::PH_IDLE)

endmodule

FILE: verif/two_wire_sensor_bus_master_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_wire_sensor_bus_master_tb
// Self-checking bench for the tick-level two-wire sensor bus master
//
// Every input word is one bus tick. A behavioral model of the bus sequencer
// predicts the pin levels and the result fields of each tick. The checker
// compares each output word with the oldest prediction. Tests cover idle
// ticks, soft reset, both measurements, status read and write, missing
// acknowledges, wait timeouts at several timeout settings, commands issued
// while busy, and a long random part with idling on both channels.
// ----------------------------------------------------------------------------
module two_wire_sensor_bus_master_tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_TICKS   = 200;
	localparam int REPORT_LIMIT   = 10;

	// start pattern of a transmission, bit k drives step k
	localparam logic [6:0] START_DATA_SEQ = 7'b1100011;
	localparam logic [6:0] START_SCK_SEQ  = 7'b0110110;

	// kind codes with no command behind them
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;

	localparam logic [17:0] TIMEOUT_MAX = 18'h3ffff;

	// how the sensor answers the bits it sends back
	typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	// one output word, in port order
	typedef struct packed {
		logic        sck;
		logic        den;
		logic        dlvl;
		logic        busy;
		logic        done;
		logic [15:0] rd;
		logic [7:0]  crc;
		logic [1:0]  err;
	} tick_out_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [17:0] timeout_ticks;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [7:0]  write_value;
	logic        data_in;
	logic        out_valid;
	logic        out_stall;
	logic        sck_level;
	logic        data_drive_enable;
	logic        data_drive_level;
	logic        busy_res;
	logic        done_res;
	logic [15:0] read_value;
	logic [7:0]  checksum;
	logic [1:0]  error_count;

	two_wire_sensor_bus_master dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.timeout_ticks    (timeout_ticks),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.write_value      (write_value),
		.data_in          (data_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sck_level        (sck_level),
		.data_drive_enable(data_drive_enable),
		.data_drive_level (data_drive_level),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.read_value       (read_value),
		.checksum         (checksum),
		.error_count      (error_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer model state
	twsb_pkg::phase_t seq_phase;
	logic [2:0]  active_cmd;
	logic [3:0]  bits_done;
	logic [1:0]  bytes_done;
	logic [7:0]  shifter;
	logic [7:0]  status_out;
	logic [15:0] read_word;
	logic [7:0]  crc_in;
	logic [17:0] busy_wait;
	logic [1:0]  fault_cnt;
	logic [17:0] timeout_cfg;

	// predicted output words still to come out of the block
	tick_out_t tick_outputs_q[$];

	// stimulus knobs
	int tx_gap_pct;
	int rx_stall_pct;
	int busy_kind_pct;
	int nack_pct;
	int wait_left;
	fill_t rd_fill;
	int stall_left;

	// bookkeeping
	int n_ticks;
	int n_txn;
	int n_nacks;
	int n_timeouts;
	int n_cfg;
	int n_checked;
	int n_fail;
	int idle_cycles;

	tick_out_t want_word;
	tick_out_t got_word;

	// advance the sequencer model by one bus tick, return the pins and results
	function automatic tick_out_t bus_tick(input logic [2:0] k, input logic [7:0] wv,
			input logic din);
		tick_out_t o;
		logic last_byte;
		int step_idx;
		o = '0;
		// a command is taken only while idle, its first step runs on the same tick
		if (seq_phase == twsb_pkg::PH_IDLE && k >= twsb_pkg::KIND_SOFT_RESET &&
				k <= twsb_pkg::KIND_WRITE_STATUS) begin
			active_cmd = k;
			fault_cnt  = '0;
			read_word  = '0;
			crc_in     = '0;
			busy_wait  = '0;
			bits_done  = '0;
			bytes_done = '0;
			shifter    = '0;
			if (k == twsb_pkg::KIND_WRITE_STATUS)
				status_out = wv;
			seq_phase = (k == twsb_pkg::KIND_SOFT_RESET) ? twsb_pkg::PH_CR_INIT :
				twsb_pkg::PH_TS_FIRST;
		end
		o.busy = (seq_phase != twsb_pkg::PH_IDLE);
		// status read has one data byte before the checksum, measurements two
		last_byte = (active_cmd == twsb_pkg::KIND_READ_STATUS) ? (bytes_done >= 2'd1) :
			(bytes_done >= 2'd2);

		if (seq_phase >= twsb_pkg::PH_TS_FIRST && seq_phase <= twsb_pkg::PH_TS_LAST) begin
			step_idx = seq_phase - twsb_pkg::PH_TS_FIRST;
			o.den  = 1'b1;
			o.dlvl = START_DATA_SEQ[step_idx];
			o.sck  = START_SCK_SEQ[step_idx];
			if (seq_phase == twsb_pkg::PH_TS_LAST) begin
				case (active_cmd)
					twsb_pkg::KIND_SOFT_RESET:   shifter = twsb_pkg::CMD_SOFT_RESET;
					twsb_pkg::KIND_MEAS_TEMP:    shifter = twsb_pkg::CMD_MEAS_TEMP;
					twsb_pkg::KIND_MEAS_HUM:     shifter = twsb_pkg::CMD_MEAS_HUM;
					twsb_pkg::KIND_READ_STATUS:  shifter = twsb_pkg::CMD_READ_STATUS;
					twsb_pkg::KIND_WRITE_STATUS: shifter = twsb_pkg::CMD_WRITE_STATUS;
					default:                     shifter = twsb_pkg::CMD_NONE;
				endcase
				bits_done  = '0;
				bytes_done = '0;
				seq_phase  = twsb_pkg::PH_WB_SET;
			end else begin
				seq_phase = twsb_pkg::phase_t'(seq_phase + 5'd1);
			end
		end else begin
			case (seq_phase)
				twsb_pkg::PH_IDLE: ;
				twsb_pkg::PH_CR_INIT: begin
					o.den = 1'b1;
					o.dlvl = 1'b1;
					bits_done = '0;
					seq_phase = twsb_pkg::PH_CR_HIGH;
				end
				twsb_pkg::PH_CR_HIGH: begin
					o.den = 1'b1;
					o.dlvl = 1'b1;
					o.sck = 1'b1;
					seq_phase = twsb_pkg::PH_CR_LOW;
				end
				twsb_pkg::PH_CR_LOW: begin
					// nine SCK pulses with data high, then a normal start
					o.den = 1'b1;
					o.dlvl = 1'b1;
					bits_done = bits_done + 4'd1;
					if (bits_done >= 4'd9) begin
						bits_done = '0;
						seq_phase = twsb_pkg::PH_TS_FIRST;
					end else begin
						seq_phase = twsb_pkg::PH_CR_HIGH;
					end
				end
				twsb_pkg::PH_WB_SET: begin
					o.den = 1'b1;
					o.dlvl = shifter[7];
					seq_phase = twsb_pkg::PH_WB_HIGH;
				end
				twsb_pkg::PH_WB_HIGH: begin
					o.den = 1'b1;
					o.dlvl = shifter[7];
					o.sck = 1'b1;
					seq_phase = twsb_pkg::PH_WB_LOW;
				end
				twsb_pkg::PH_WB_LOW: begin
					o.den = 1'b1;
					o.dlvl = shifter[7];
					shifter = {shifter[6:0], 1'b0};
					bits_done = bits_done + 4'd1;
					seq_phase = (bits_done >= 4'd8) ? twsb_pkg::PH_WB_REL :
						twsb_pkg::PH_WB_SET;
				end
				twsb_pkg::PH_WB_REL: seq_phase = twsb_pkg::PH_WB_AHIGH;
				twsb_pkg::PH_WB_AHIGH: begin
					o.sck = 1'b1;
					seq_phase = twsb_pkg::PH_WB_ALOW;
				end
				twsb_pkg::PH_WB_ALOW: begin
					// sensor acknowledge, data high means it is missing
					if (din) begin
						n_nacks++;
						if (fault_cnt != 2'd3)
							fault_cnt = fault_cnt + 2'd1;
					end
					bits_done = '0;
					if (active_cmd == twsb_pkg::KIND_WRITE_STATUS && bytes_done == 2'd0) begin
						bytes_done = 2'd1;
						shifter = status_out;
						seq_phase = twsb_pkg::PH_WB_SET;
					end else if (active_cmd == twsb_pkg::KIND_MEAS_TEMP ||
							active_cmd == twsb_pkg::KIND_MEAS_HUM) begin
						busy_wait = '0;
						seq_phase = twsb_pkg::PH_WAIT;
					end else if (active_cmd == twsb_pkg::KIND_READ_STATUS) begin
						bytes_done = '0;
						shifter = '0;
						seq_phase = twsb_pkg::PH_RB_HIGH;
					end else begin
						o.done = 1'b1;
						seq_phase = twsb_pkg::PH_IDLE;
					end
				end
				twsb_pkg::PH_WAIT: begin
					// data low ends the wait, otherwise count toward the timeout
					if (din) begin
						busy_wait = busy_wait + 18'd1;
						if (busy_wait >= timeout_cfg) begin
							n_timeouts++;
							if (fault_cnt != 2'd3)
								fault_cnt = fault_cnt + 2'd1;
							seq_phase = twsb_pkg::PH_RB_HIGH;
						end
					end else begin
						seq_phase = twsb_pkg::PH_RB_HIGH;
					end
					if (seq_phase == twsb_pkg::PH_RB_HIGH) begin
						bytes_done = '0;
						bits_done = '0;
						shifter = '0;
					end
				end
				twsb_pkg::PH_RB_HIGH: begin
					o.sck = 1'b1;
					seq_phase = twsb_pkg::PH_RB_LOW;
				end
				twsb_pkg::PH_RB_LOW: begin
					shifter = {shifter[6:0], din};
					bits_done = bits_done + 4'd1;
					if (bits_done >= 4'd8) begin
						if (last_byte)
							crc_in = shifter;
						else if (active_cmd == twsb_pkg::KIND_READ_STATUS)
							read_word = {8'h00, shifter};
						else if (bytes_done == 2'd0)
							read_word = {shifter, 8'h00};
						else
							read_word[7:0] = shifter;
						seq_phase = twsb_pkg::PH_RB_ASET;
					end else begin
						seq_phase = twsb_pkg::PH_RB_HIGH;
					end
				end
				twsb_pkg::PH_RB_ASET, twsb_pkg::PH_RB_AHIGH, twsb_pkg::PH_RB_ALOW: begin
					// master ack: low for data bytes, high after the checksum
					o.den = 1'b1;
					o.dlvl = last_byte;
					if (seq_phase == twsb_pkg::PH_RB_ASET) begin
						seq_phase = twsb_pkg::PH_RB_AHIGH;
					end else if (seq_phase == twsb_pkg::PH_RB_AHIGH) begin
						o.sck = 1'b1;
						seq_phase = twsb_pkg::PH_RB_ALOW;
					end else begin
						seq_phase = twsb_pkg::PH_RB_REL;
					end
				end
				twsb_pkg::PH_RB_REL: begin
					if (last_byte) begin
						o.done = 1'b1;
						seq_phase = twsb_pkg::PH_IDLE;
					end else begin
						bytes_done = bytes_done + 2'd1;
						bits_done = '0;
						shifter = '0;
						seq_phase = twsb_pkg::PH_RB_HIGH;
					end
				end
				default: begin
					o.busy = 1'b0;
					seq_phase = twsb_pkg::PH_IDLE;
				end
			endcase
		end

		// result fields only carry data on the finishing tick
		if (o.done) begin
			o.rd  = read_word;
			o.crc = crc_in;
			o.err = fault_cnt;
		end
		return o;
	endfunction

	// sensor side of the DATA line for the tick about to be sent
	function automatic logic sensor_data();
		case (seq_phase)
			twsb_pkg::PH_WB_ALOW: return ($urandom_range(0, 99) < nack_pct);
			twsb_pkg::PH_WAIT: begin
				if (wait_left > 0) begin
					wait_left--;
					return 1'b1;
				end
				return 1'b0;
			end
			twsb_pkg::PH_RB_LOW: begin
				if (rd_fill == FILL_ONES)
					return 1'b1;
				if (rd_fill == FILL_ZEROS)
					return 1'b0;
				return 1'($urandom_range(0, 1));
			end
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// kind field while busy: mostly a plain tick, sometimes a command to be ignored
	function automatic logic [2:0] busy_kind();
		if ($urandom_range(0, 99) < busy_kind_pct)
			return 3'($urandom_range(0, 7));
		return twsb_pkg::KIND_TICK;
	endfunction

	function automatic string fmt_word(input tick_out_t w);
		return $sformatf("sck=%0b en=%0b lvl=%0b busy=%0b done=%0b rd=%04h crc=%02h err=%0d",
			w.sck, w.den, w.dlvl, w.busy, w.done, w.rd, w.crc, w.err);
	endfunction

	// send one tick word, called and returning at a falling edge
	task automatic send_tick(input logic [2:0] k, input logic [7:0] wv, input logic din);
		tick_out_t pred;
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		write_value <= wv;
		data_in     <= din;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = bus_tick(k, wv, din);
		tick_outputs_q.push_back(pred);
		n_ticks++;
		@(negedge clk);
	endtask

	// one whole command, from the idle tick that issues it to its done tick
	task automatic run_txn(input logic [2:0] k, input logic [7:0] wv, input int wait_hi,
			input int nack, input fill_t fill);
		wait_left = wait_hi;
		nack_pct  = nack;
		rd_fill   = fill;
		send_tick(k, wv, 1'($urandom_range(0, 1)));
		while (seq_phase != twsb_pkg::PH_IDLE)
			send_tick(busy_kind(), 8'($urandom_range(0, 255)), sensor_data());
		n_txn++;
	endtask

	// plain ticks while idle, kind 0 or one of the unused codes
	task automatic idle_ticks(input int n);
		logic [2:0] k;
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: k = twsb_pkg::KIND_TICK;
				1: k = KIND_SPARE_A;
				default: k = KIND_SPARE_B;
			endcase
			send_tick(k, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	// stop sending and wait for every predicted word to come out
	task automatic drain();
		in_valid <= 1'b0;
		while (tick_outputs_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// rewrite the timeout only with nothing in flight
	task automatic write_timeout(input logic [17:0] v);
		drain();
		cfg_valid     <= 1'b1;
		timeout_ticks <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		timeout_cfg = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// idle ticks right after reset, unused kinds must be ignored like kind 0
	task automatic test_idle_and_unused();
		send_tick(twsb_pkg::KIND_TICK, 8'h00, 1'b0);
		send_tick(KIND_SPARE_A, 8'hff, 1'b1);
		send_tick(KIND_SPARE_B, 8'h5a, 1'b0);
		send_tick(twsb_pkg::KIND_TICK, 8'ha5, 1'b1);
	endtask

	// connection reset then soft reset command, acked and not acked
	task automatic test_soft_reset();
		run_txn(twsb_pkg::KIND_SOFT_RESET, 8'h00, 0, 0, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_SOFT_RESET, 8'hff, 0, 100, FILL_RANDOM);
	endtask

	// both measurements with the reset timeout, data extremes from the sensor
	task automatic test_measurements();
		run_txn(twsb_pkg::KIND_MEAS_TEMP, 8'h00, 0, 0, FILL_ONES);
		run_txn(twsb_pkg::KIND_MEAS_HUM, 8'hff, 3, 0, FILL_ZEROS);
		run_txn(twsb_pkg::KIND_MEAS_TEMP, 8'h3c, 1, 0, FILL_RANDOM);
	endtask

	// status read and write, the write with both acks missing
	task automatic test_status();
		run_txn(twsb_pkg::KIND_READ_STATUS, 8'h00, 0, 0, FILL_ONES);
		run_txn(twsb_pkg::KIND_READ_STATUS, 8'h00, 0, 100, FILL_ZEROS);
		run_txn(twsb_pkg::KIND_WRITE_STATUS, 8'hff, 0, 0, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_WRITE_STATUS, 8'h00, 0, 100, FILL_RANDOM);
	endtask

	// wait timeout around its boundary at several settings
	task automatic test_wait_timeout();
		// zero times out on the first tick that sees data high
		write_timeout(18'd0);
		run_txn(twsb_pkg::KIND_MEAS_TEMP, 8'h00, 2, 0, FILL_RANDOM);
		write_timeout(18'd1);
		run_txn(twsb_pkg::KIND_MEAS_HUM, 8'h00, 1, 0, FILL_RANDOM);
		write_timeout(18'd5);
		// one short of the limit, then exactly at it with a missing ack too
		run_txn(twsb_pkg::KIND_MEAS_TEMP, 8'h00, 4, 0, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_MEAS_HUM, 8'h00, 5, 100, FILL_RANDOM);
		write_timeout(TIMEOUT_MAX);
		run_txn(twsb_pkg::KIND_MEAS_TEMP, 8'h00, 12, 0, FILL_RANDOM);
	endtask

	// commands thrown at the block while it is busy are ignored
	task automatic test_busy_commands();
		busy_kind_pct = 100;
		run_txn(twsb_pkg::KIND_READ_STATUS, 8'h81, 0, 0, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_MEAS_HUM, 8'h42, 2, 0, FILL_RANDOM);
		busy_kind_pct = 25;
	endtask

	// random transactions with random idling and timeout changes
	task automatic test_random();
		int txn_ticks;
		int start;
		int wait_hi;
		int r;
		logic [2:0] k;
		fill_t fill;
		txn_ticks = 0;
		while (txn_ticks < RANDOM_TICKS) begin
			// pick an idling style for this stretch, none at times
			case ($urandom_range(0, 3))
				0: begin tx_gap_pct = 0; rx_stall_pct = 0; end
				1: begin tx_gap_pct = 10; rx_stall_pct = 5; end
				2: begin tx_gap_pct = 3; rx_stall_pct = 25; end
				default: begin tx_gap_pct = 25; rx_stall_pct = 10; end
			endcase
			r = $urandom_range(0, 99);
			if (r < 10) begin
				case ($urandom_range(0, 6))
					0: write_timeout(18'd0);
					1: write_timeout(18'd1);
					2: write_timeout(TIMEOUT_MAX);
					3: write_timeout(twsb_pkg::TIMEOUT_RESET);
					4: write_timeout(18'($urandom_range(0, 262143)));
					default: write_timeout(18'($urandom_range(2, 40)));
				endcase
			end else if (r < 22) begin
				idle_ticks($urandom_range(1, 4));
			end else begin
				k = 3'($urandom_range(twsb_pkg::KIND_SOFT_RESET, twsb_pkg::KIND_WRITE_STATUS));
				// force a timeout now and then when the setting is short
				if (timeout_cfg <= 18'd40 && $urandom_range(0, 3) == 0)
					wait_hi = timeout_cfg + $urandom_range(0, 3);
				else
					wait_hi = $urandom_range(0, 6);
				case ($urandom_range(0, 5))
					0: fill = FILL_ONES;
					1: fill = FILL_ZEROS;
					default: fill = FILL_RANDOM;
				endcase
				start = n_ticks;
				run_txn(k, 8'($urandom_range(0, 255)), wait_hi, 8, fill);
				txn_ticks += n_ticks - start;
			end
		end
	endtask

	// closing stretch at full rate, no idling on either side
	task automatic test_full_rate();
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		write_timeout(18'd3);
		run_txn(twsb_pkg::KIND_SOFT_RESET, 8'($urandom_range(0, 255)), 0, 8, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_MEAS_TEMP, 8'($urandom_range(0, 255)), 4, 8, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_MEAS_HUM, 8'($urandom_range(0, 255)), 1, 8, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_READ_STATUS, 8'($urandom_range(0, 255)), 0, 8, FILL_RANDOM);
		run_txn(twsb_pkg::KIND_WRITE_STATUS, 8'($urandom_range(0, 255)), 0, 8, FILL_RANDOM);
		idle_ticks(3);
	endtask

	// ------------------------------------------------------------------------
	// receiver stall, in random bursts of random length
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// checker: every accepted output word against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_word = {sck_level, data_drive_enable, data_drive_level, busy_res, done_res,
				read_value, checksum, error_count};
			if (tick_outputs_q.size() == 0) begin
				n_fail++;
				if (n_fail <= REPORT_LIMIT)
					$display("%0t: output word with nothing predicted: %s", $realtime,
						fmt_word(got_word));
			end else begin
				want_word = tick_outputs_q.pop_front();
				n_checked++;
				if (got_word.sck !== want_word.sck || got_word.den !== want_word.den ||
						got_word.dlvl !== want_word.dlvl || got_word.busy !== want_word.busy ||
						got_word.done !== want_word.done || got_word.rd !== want_word.rd ||
						got_word.crc !== want_word.crc || got_word.err !== want_word.err) begin
					n_fail++;
					if (n_fail <= REPORT_LIMIT) begin
						$display("%0t: mismatch on word %0d", $realtime, n_checked);
						$display("  expected %s", fmt_word(want_word));
						$display("  actual   %s", fmt_word(got_word));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any word moving on any channel
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d words outstanding",
					idle_cycles, tick_outputs_q.size());
				$display("two_wire_sensor_bus_master test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		timeout_ticks = '0;
		in_valid      = 1'b0;
		kind          = twsb_pkg::KIND_TICK;
		write_value   = '0;
		data_in       = 1'b0;
		out_stall     = 1'b0;
		stall_left    = 0;
		idle_cycles   = 0;

		// model state after reset
		seq_phase   = twsb_pkg::PH_IDLE;
		active_cmd  = '0;
		bits_done   = '0;
		bytes_done  = '0;
		shifter     = '0;
		status_out  = '0;
		read_word   = '0;
		crc_in      = '0;
		busy_wait   = '0;
		fault_cnt   = '0;
		timeout_cfg = twsb_pkg::TIMEOUT_RESET;

		n_ticks = 0;
		n_txn = 0;
		n_nacks = 0;
		n_timeouts = 0;
		n_cfg = 0;
		n_checked = 0;
		n_fail = 0;

		// directed part runs with light idling
		tx_gap_pct    = 10;
		rx_stall_pct  = 10;
		busy_kind_pct = 25;
		nack_pct      = 0;
		wait_left     = 0;
		rd_fill       = FILL_RANDOM;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_and_unused();
		test_soft_reset();
		test_measurements();
		test_status();
		test_wait_timeout();
		test_busy_commands();
		test_random();
		test_full_rate();

		drain();
		repeat (10) @(negedge clk);

		$display("%0d bus ticks in %0d transactions, %0d missing acks, %0d wait timeouts",
			n_ticks, n_txn, n_nacks, n_timeouts);
		$display("%0d timeout settings written, %0d output words checked, %0d failures",
			n_cfg, n_checked, n_fail);
		if (n_fail == 0 && tick_outputs_q.size() == 0) begin
			$display("two_wire_sensor_bus_master test passed");
		end else begin
			$display("two_wire_sensor_bus_master test failed");
		end
		$finish;
	end

endmodule
